// ===== rtl/core/smts_pkg.sv =====
// Package with the beat types and fixed codes of the sorted timer scheduler.
`timescale 1ns / 1ps
package smts_pkg;

    // Command beat.
    typedef struct packed {
        logic [2:0]  action;
        logic [3:0]  timer_index;
        logic [31:0] new_data;
        logic [31:0] delay;
    } cmd_t;

    // Result beat.
    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  slot;
        logic [31:0] fire_data;
        logic        last;
    } rsp_t;

    // Action codes.
    localparam logic [2:0] A_ALLOC = 3'd0;
    localparam logic [2:0] A_FREE  = 3'd1;
    localparam logic [2:0] A_SET   = 3'd2;
    localparam logic [2:0] A_ARM   = 3'd3;
    localparam logic [2:0] A_TICK  = 3'd4;

    // Result kinds.
    localparam logic [2:0] K_ALLOC = 3'd0;
    localparam logic [2:0] K_FULL  = 3'd1;
    localparam logic [2:0] K_DONE  = 3'd2;
    localparam logic [2:0] K_FIRE  = 3'd3;
    localparam logic [2:0] K_ERR   = 3'd4;

    // Slot status codes.
    localparam logic [1:0] ST_FREE  = 2'd0;
    localparam logic [1:0] ST_ALLOC = 2'd1;
    localparam logic [1:0] ST_RUN   = 2'd2;

    // Most timers fired by a single tick, and the end-of-list deadline.
    localparam int          MAX_OUT  = 16;
    localparam logic [31:0] ALL_ONES = 32'hffff_ffff;

endpackage

// ===== rtl/core/smts_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
module smts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/smts_alloc.sv =====
// Lowest-free-slot finder over the slot free mask.
`timescale 1ns / 1ps
module smts_alloc #(
    parameter int NUM_TIMERS = 16
) (
    input  logic [NUM_TIMERS-1:0]         free_mask,
    output logic                          found,
    output logic [$clog2(NUM_TIMERS)-1:0] idx
);

    // Scan from the top so the lowest free slot wins.
    always_comb
    begin
        found = 1'b0;
        idx   = '0;
        for (int i = NUM_TIMERS - 1; i >= 0; i--)
        begin
            if (free_mask[i])
            begin
                found = 1'b1;
                idx   = ($clog2(NUM_TIMERS))'(i);
            end
        end
    end

endmodule

// ===== rtl/core/sorted_multi_timer_scheduler_unit.sv =====
// Top level of the sorted timer scheduler: control sequencer around the list RAMs.
// Allocate, free, set data, errors and a tick that fires nothing each give one result beat
// from the response state. Arm first walks the list, up to NUM_TIMERS entries, then writes
// the slot's deadline and link and, unless it goes in at the head, the predecessor's link;
// a firing tick gives one beat per fired timer, the last one marked. One command is in
// work at a time. Reset clears the count, head, status flops and output valid; RAMs are not.
`timescale 1ns / 1ps
module sorted_multi_timer_scheduler_unit #(
    parameter int NUM_TIMERS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  smts_pkg::cmd_t      cmd,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output smts_pkg::rsp_t      rsp
);

    localparam int IW = $clog2(NUM_TIMERS);
    localparam int PW = $clog2(NUM_TIMERS + 1);
    localparam int DW = 32 + PW;
    localparam int CW = $clog2(smts_pkg::MAX_OUT + 1);
    localparam logic [PW-1:0] SENT = PW'(NUM_TIMERS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_WALK  = 3'd1;
    localparam logic [2:0] S_LINK  = 3'd2;
    localparam logic [2:0] S_LINKP = 3'd3;
    localparam logic [2:0] S_FIRE  = 3'd4;
    localparam logic [2:0] S_RESP  = 3'd5;

    logic [2:0]     state_reg, state_next;
    logic [31:0]    count_reg, count_next;
    logic [31:0]    earliest_reg, earliest_next;
    logic [PW-1:0]  head_reg, head_next;
    logic [PW-1:0]  cur_reg, cur_next;
    logic [PW-1:0]  prev_reg, prev_next;
    logic [31:0]    prev_dl_reg, prev_dl_next;
    logic [31:0]    dl_reg, dl_next;
    logic [IW-1:0]  idx_reg, idx_next;
    logic [CW-1:0]  n_reg, n_next;
    logic           pend_valid_reg, pend_valid_next;
    logic [IW-1:0]  pend_slot_reg, pend_slot_next;
    logic [31:0]    pend_data_reg, pend_data_next;
    smts_pkg::rsp_t res_reg, res_next;
    logic           rsp_valid_reg, rsp_valid_next;
    smts_pkg::rsp_t rsp_reg, rsp_next;
    logic [1:0]     status_reg [NUM_TIMERS];

    logic                  status_we;
    logic [IW-1:0]         status_waddr;
    logic [1:0]            status_wdata;
    logic [NUM_TIMERS-1:0] free_mask;
    logic                  alloc_found;
    logic [IW-1:0]         alloc_idx;

    logic [IW-1:0] rd_addr;
    logic [DW-1:0] dq_rdata;
    logic          dq_we;
    logic [IW-1:0] dq_waddr;
    logic [DW-1:0] dq_wdata;
    logic [31:0]   dat_rdata;
    logic          dat_we;

    logic          accept;
    logic [IW-1:0] cmd_idx;
    logic          idx_ok;
    logic          running;
    logic [31:0]   tick_next;
    logic [31:0]   rd_dl;
    logic [PW-1:0] rd_next;
    logic          out_free;
    logic          head_ok;
    logic          fire_now;

    // Deadline and link of each slot share one RAM word.
    smts_ram #(.WIDTH(DW), .DEPTH(NUM_TIMERS)) u_dq_ram (
        .clk   (clk),
        .we    (dq_we),
        .waddr (dq_waddr),
        .wdata (dq_wdata),
        .raddr (rd_addr),
        .rdata (dq_rdata)
    );

    // Event data of each slot.
    smts_ram #(.WIDTH(32), .DEPTH(NUM_TIMERS)) u_data_ram (
        .clk   (clk),
        .we    (dat_we),
        .waddr (cmd_idx),
        .wdata (cmd.new_data),
        .raddr (rd_addr),
        .rdata (dat_rdata)
    );

    // Free mask for the allocator.
    always_comb
    begin
        for (int i = 0; i < NUM_TIMERS; i++)
        begin
            free_mask[i] = (status_reg[i] == smts_pkg::ST_FREE);
        end
    end

    smts_alloc #(.NUM_TIMERS(NUM_TIMERS)) u_alloc (
        .free_mask (free_mask),
        .found     (alloc_found),
        .idx       (alloc_idx)
    );

    assign cmd_stall = (state_reg != S_IDLE);
    assign accept    = cmd_valid && !cmd_stall;
    assign cmd_idx   = IW'(cmd.timer_index);
    assign idx_ok    = 32'(cmd.timer_index) < 32'(NUM_TIMERS);
    assign running   = (status_reg[cmd_idx] == smts_pkg::ST_RUN);
    assign tick_next = count_reg + 32'd1;
    assign rd_dl     = dq_rdata[31:0];
    assign rd_next   = dq_rdata[DW-1:32];
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign head_ok   = (head_reg != SENT);
    assign fire_now  = head_ok && (rd_dl <= count_reg)
                       && (n_reg < CW'(smts_pkg::MAX_OUT));

    // Sequencer: every access to the list RAM is ordered by state, so reads and
    // writes of the same entry never overlap.
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        earliest_next   = earliest_reg;
        head_next       = head_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        prev_dl_next    = prev_dl_reg;
        dl_next         = dl_reg;
        idx_next        = idx_reg;
        n_next          = n_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        pend_data_next  = pend_data_reg;
        res_next        = res_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        rsp_next        = rsp_reg;
        status_we       = 1'b0;
        status_waddr    = cmd_idx;
        status_wdata    = smts_pkg::ST_FREE;
        rd_addr         = head_reg[IW-1:0];
        dq_we           = 1'b0;
        dq_waddr        = idx_reg;
        dq_wdata        = {cur_reg, dl_reg};
        dat_we          = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_RESP;
                    res_next   = '{kind: smts_pkg::K_DONE, slot: 4'd0,
                                   fire_data: 32'd0, last: 1'b1};
                    unique case (cmd.action)
                        smts_pkg::A_ALLOC:
                        begin
                            if (alloc_found)
                            begin
                                status_we     = 1'b1;
                                status_waddr  = alloc_idx;
                                status_wdata  = smts_pkg::ST_ALLOC;
                                res_next.kind = smts_pkg::K_ALLOC;
                                res_next.slot = 4'(alloc_idx);
                            end
                            else
                            begin
                                res_next.kind = smts_pkg::K_FULL;
                            end
                        end
                        smts_pkg::A_FREE:
                        begin
                            if (!idx_ok || running)
                            begin
                                res_next.kind = smts_pkg::K_ERR;
                            end
                            else
                            begin
                                status_we = 1'b1;
                            end
                        end
                        smts_pkg::A_SET:
                        begin
                            if (!idx_ok)
                            begin
                                res_next.kind = smts_pkg::K_ERR;
                            end
                            else
                            begin
                                dat_we = 1'b1;
                            end
                        end
                        smts_pkg::A_ARM:
                        begin
                            if (!idx_ok || running)
                            begin
                                res_next.kind = smts_pkg::K_ERR;
                            end
                            else
                            begin
                                dl_next    = count_reg + cmd.delay;
                                idx_next   = cmd_idx;
                                cur_next   = head_reg;
                                prev_next  = SENT;
                                state_next = S_WALK;
                            end
                        end
                        smts_pkg::A_TICK:
                        begin
                            count_next = tick_next;
                            if (earliest_reg <= tick_next)
                            begin
                                n_next          = '0;
                                pend_valid_next = 1'b0;
                                state_next      = S_FIRE;
                            end
                        end
                        default:
                        begin
                            res_next.kind = smts_pkg::K_ERR;
                        end
                    endcase
                end
            end

            // One list entry per cycle: the next address comes straight from read data.
            S_WALK:
            begin
                if (cur_reg == SENT || dl_reg <= rd_dl)
                begin
                    state_next = S_LINK;
                end
                else
                begin
                    prev_next    = cur_reg;
                    prev_dl_next = rd_dl;
                    cur_next     = rd_next;
                    rd_addr      = rd_next[IW-1:0];
                end
            end

            // Write the armed slot's deadline and link.
            S_LINK:
            begin
                dq_we        = 1'b1;
                status_we    = 1'b1;
                status_waddr = idx_reg;
                status_wdata = smts_pkg::ST_RUN;
                if (prev_reg == SENT)
                begin
                    head_next     = PW'(idx_reg);
                    earliest_next = dl_reg;
                    state_next    = S_RESP;
                end
                else
                begin
                    state_next = S_LINKP;
                end
            end

            // Point the predecessor at the armed slot.
            S_LINKP:
            begin
                dq_we      = 1'b1;
                dq_waddr   = prev_reg[IW-1:0];
                dq_wdata   = {PW'(idx_reg), prev_dl_reg};
                state_next = S_RESP;
            end

            // Fired timers are held one beat so the last one can be marked.
            S_FIRE:
            begin
                if (pend_valid_reg && !out_free)
                begin
                    rd_addr = head_reg[IW-1:0];
                end
                else
                begin
                    if (pend_valid_reg)
                    begin
                        rsp_valid_next = 1'b1;
                        rsp_next = '{kind: smts_pkg::K_FIRE, slot: 4'(pend_slot_reg),
                                     fire_data: pend_data_reg, last: !fire_now};
                    end
                    if (fire_now)
                    begin
                        pend_valid_next = 1'b1;
                        pend_slot_next  = head_reg[IW-1:0];
                        pend_data_next  = dat_rdata;
                        status_we       = 1'b1;
                        status_waddr    = head_reg[IW-1:0];
                        status_wdata    = smts_pkg::ST_ALLOC;
                        head_next       = rd_next;
                        n_next          = n_reg + CW'(1);
                        rd_addr         = rd_next[IW-1:0];
                    end
                    else
                    begin
                        pend_valid_next = 1'b0;
                        earliest_next   = head_ok ? rd_dl : smts_pkg::ALL_ONES;
                        state_next      = pend_valid_reg ? S_IDLE : S_RESP;
                    end
                end
            end

            // Hand a single result beat to the output register.
            S_RESP:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = res_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= 32'd0;
            earliest_reg   <= smts_pkg::ALL_ONES;
            head_reg       <= SENT;
            n_reg          <= '0;
            pend_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            earliest_reg   <= earliest_next;
            head_reg       <= head_next;
            n_reg          <= n_next;
            pend_valid_reg <= pend_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        prev_reg      <= prev_next;
        prev_dl_reg   <= prev_dl_next;
        dl_reg        <= dl_next;
        idx_reg       <= idx_next;
        pend_slot_reg <= pend_slot_next;
        pend_data_reg <= pend_data_next;
        res_reg       <= res_next;
        rsp_reg       <= rsp_next;
    end

    // Slot status flops.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                status_reg[i] <= smts_pkg::ST_FREE;
            end
        end
        else if (status_we)
        begin
            status_reg[status_waddr] <= status_wdata;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // The list head is a real slot or the end marker.
    assert property (@(posedge clk) disable iff (!rst_n) head_reg <= SENT)
        else $error("list head out of range");

    // An empty list leaves the earliest deadline at the end marker.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && head_reg == SENT) |-> earliest_reg == smts_pkg::ALL_ONES)
        else $error("earliest deadline stale on empty list");

    // A tick never fires more than the per-tick limit.
    assert property (@(posedge clk) disable iff (!rst_n) n_reg <= CW'(smts_pkg::MAX_OUT))
        else $error("fire count over limit");

endmodule
